// File: rtl/spof_pkg.sv
// Shared constants and the arctangent table for the ridge orientation field.
`timescale 1ns / 1ps
`default_nettype none
package spof_pkg;

	// Defaults for the top-level parameters
	localparam int DEF_MAX_CORES  = 2;
	localparam int DEF_MAX_DELTAS = 2;
	localparam int DEF_COORD_BITS = 10;
	localparam int DEF_ANGLE_BITS = 16;

	// Position registers present for each kind of singular point
	localparam int NUM_POS_REGS = 2;

	// Fraction bits of a position and pre-scale of the rotation datapath
	localparam int FRAC_BITS = 4;
	localparam int PRE_SHIFT = 16;

	// Micro-rotations and width of the angle accumulator (unit 2^-32 turn)
	localparam int CORDIC_STEPS = 28;
	localparam int ACC_W        = 34;
	localparam int TAB_W        = 30;

	// Width of the result word
	localparam int OUT_W = 18;

	// atan(2^-i) in units of 2^-32 turn
	localparam logic [TAB_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
		30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
		30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
		30'd166886,    30'd83443,     30'd41722,     30'd20861,
		30'd10430,     30'd5215,      30'd2608,      30'd1304,
		30'd652,       30'd326,       30'd163,       30'd81,
		30'd41,        30'd20,        30'd10,        30'd5
	};

endpackage
`default_nettype wire

// File: rtl/singular_point_orientation_field.sv
// Top level of the ridge orientation field: registers, entry stage, rotation chain, output.
//
// Each pixel word presented with start (while busy is low) yields one ridge_angle word,
// marked by done for one cycle, after one entry stage, a chain of 28
// rotation cells (one micro-rotation each, all singular points side by side in lanes) and
// two output stages. A new pixel may enter every cycle, so a raster stream runs at one
// pixel per clock; busy is high only while the block is held in reset and the cycle after.
// The result cannot be stalled and must be taken in the cycle done is high. ridge_angle is
// half the sum of core angles minus delta angles in units of 2*pi/2^ANGLE_BITS, not wrapped.
// Write counts and positions only while no pixel is in flight.
`timescale 1ns / 1ps
`default_nettype none
module singular_point_orientation_field #(
	parameter int MAX_CORES  = spof_pkg::DEF_MAX_CORES,
	parameter int MAX_DELTAS = spof_pkg::DEF_MAX_DELTAS,
	parameter int COORD_BITS = spof_pkg::DEF_COORD_BITS,
	parameter int ANGLE_BITS = spof_pkg::DEF_ANGLE_BITS
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        start,
	output logic                                        busy,
	input  logic [COORD_BITS-1:0]                       pixel_x,
	input  logic [COORD_BITS-1:0]                       pixel_y,
	output logic                                        done,
	output logic signed [spof_pkg::OUT_W-1:0]           ridge_angle,
	input  logic                                        wr_en,
	input  logic [2:0]                                  wr_index,
	input  logic [2*(COORD_BITS+spof_pkg::FRAC_BITS)-1:0] wr_data
);

	localparam int PB    = COORD_BITS + spof_pkg::FRAC_BITS;
	localparam int NC    = (MAX_CORES < spof_pkg::NUM_POS_REGS) ?
		MAX_CORES : spof_pkg::NUM_POS_REGS;
	localparam int ND    = (MAX_DELTAS < spof_pkg::NUM_POS_REGS) ?
		MAX_DELTAS : spof_pkg::NUM_POS_REGS;
	localparam int LANES = NC + ND;
	localparam int XW    = PB + 20;
	localparam int AW    = spof_pkg::ACC_W;
	localparam int STEPS = spof_pkg::CORDIC_STEPS;
	localparam int LATENCY = STEPS + 3;

	// Register indexes
	localparam logic [2:0] REG_CORE_COUNT  = 3'd0;
	localparam logic [2:0] REG_DELTA_COUNT = 3'd1;
	localparam logic [2:0] REG_CORE0_POS   = 3'd2;
	localparam logic [2:0] REG_CORE1_POS   = 3'd3;
	localparam logic [2:0] REG_DELTA0_POS  = 3'd4;
	localparam logic [2:0] REG_DELTA1_POS  = 3'd5;

	localparam logic signed [AW-1:0] QUARTER = AW'(64'sd1 <<< 30);
	localparam logic signed [AW-1:0] HALF    = AW'(64'sd1 <<< 31);

	logic          busy_q;
	logic [1:0]    core_count_q;
	logic [1:0]    delta_count_q;
	logic [2*PB-1:0] core_pos_q [spof_pkg::NUM_POS_REGS];
	logic [2*PB-1:0] delta_pos_q [spof_pkg::NUM_POS_REGS];
	logic [2*PB-1:0] lane_pos [LANES];
	logic          accept;

	logic                 valid_c [STEPS+1];
	logic signed [XW-1:0] x_c [STEPS+1][LANES];
	logic signed [XW-1:0] y_c [STEPS+1][LANES];
	logic signed [AW-1:0] acc_c [STEPS+1][LANES];
	logic                 hold_c [STEPS+1][LANES];
	logic                 en_c [STEPS+1][LANES];

	assign accept = start && !busy_q;
	assign busy   = busy_q;

	// Hold busy through reset and the cycle after it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			busy_q <= 1'b1;
		else
			busy_q <= 1'b0;
	end

	// Take register writes; unknown indexes drop the word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			core_count_q  <= '0;
			delta_count_q <= '0;
			for (int i = 0; i < spof_pkg::NUM_POS_REGS; i++) begin
				core_pos_q[i]  <= '0;
				delta_pos_q[i] <= '0;
			end
		end else if (wr_en) begin
			case (wr_index)
				REG_CORE_COUNT:  core_count_q   <= wr_data[1:0];
				REG_DELTA_COUNT: delta_count_q  <= wr_data[1:0];
				REG_CORE0_POS:   core_pos_q[0]  <= wr_data;
				REG_CORE1_POS:   core_pos_q[1]  <= wr_data;
				REG_DELTA0_POS:  delta_pos_q[0] <= wr_data;
				REG_DELTA1_POS:  delta_pos_q[1] <= wr_data;
				default: ;
			endcase
		end
	end

	// Route positions to lanes: cores first, then deltas
	for (genvar k = 0; k < LANES; k++) begin : g_lane
		if (k < NC) begin : g_core
			assign lane_pos[k] = core_pos_q[k];
		end else begin : g_delta
			assign lane_pos[k] = delta_pos_q[k - NC];
		end
	end

	spof_front #(
		.COORD_BITS (COORD_BITS),
		.LANES      (LANES),
		.NC         (NC),
		.XW         (XW)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.core_count  (core_count_q),
		.delta_count (delta_count_q),
		.pos         (lane_pos),
		.valid_out   (valid_c[0]),
		.x_out       (x_c[0]),
		.y_out       (y_c[0]),
		.acc_out     (acc_c[0]),
		.hold_out    (hold_c[0]),
		.en_out      (en_c[0])
	);

	// Chain of rotation cells, one micro-rotation per cell
	for (genvar i = 0; i < STEPS; i++) begin : g_cell
		spof_cell #(
			.STEP  (i),
			.LANES (LANES),
			.XW    (XW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.valid_in  (valid_c[i]),
			.x_in      (x_c[i]),
			.y_in      (y_c[i]),
			.acc_in    (acc_c[i]),
			.hold_in   (hold_c[i]),
			.en_in     (en_c[i]),
			.valid_out (valid_c[i+1]),
			.x_out     (x_c[i+1]),
			.y_out     (y_c[i+1]),
			.acc_out   (acc_c[i+1]),
			.hold_out  (hold_c[i+1]),
			.en_out    (en_c[i+1])
		);
	end

	spof_sum #(
		.ANGLE_BITS (ANGLE_BITS),
		.LANES      (LANES),
		.NC         (NC)
	) u_sum (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_in    (valid_c[STEPS]),
		.acc_in      (acc_c[STEPS]),
		.en_in       (en_c[STEPS]),
		.done        (done),
		.ridge_angle (ridge_angle)
	);

	// Every accepted pixel gives exactly one word, a fixed latency later
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done == $past(accept, LATENCY))
		else $error("result strobe out of step with accepted pixels");

	// An exact-case lane 0 leaves the chain with its axis angle untouched
	a_exact: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_c[STEPS] && hold_c[STEPS][0]) |->
		(acc_c[STEPS][0] == '0 || acc_c[STEPS][0] == QUARTER ||
		 acc_c[STEPS][0] == -QUARTER || acc_c[STEPS][0] == HALF))
		else $error("exact-case lane angle disturbed in the chain");

	// With no singular point enabled the field is flat
	a_flat: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(core_count_q == '0 && delta_count_q == '0, LATENCY)) |->
		(ridge_angle == '0))
		else $error("non-zero angle with no enabled points");

	// No pixel enters while busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> !valid_c[0])
		else $error("pixel taken while busy");

endmodule
`default_nettype wire

// File: rtl/spof_front.sv
// Entry stage: offsets to each singular point, exact cases and quarter-turn pre-rotation.
`timescale 1ns / 1ps
`default_nettype none
module spof_front #(
	parameter int COORD_BITS = spof_pkg::DEF_COORD_BITS,
	parameter int LANES      = 4,
	parameter int NC         = 2,
	parameter int XW         = 34
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        accept,
	input  logic [COORD_BITS-1:0]                       pixel_x,
	input  logic [COORD_BITS-1:0]                       pixel_y,
	input  logic [1:0]                                  core_count,
	input  logic [1:0]                                  delta_count,
	input  logic [2*(COORD_BITS+spof_pkg::FRAC_BITS)-1:0] pos [LANES],
	output logic                                        valid_out,
	output logic signed [XW-1:0]                        x_out [LANES],
	output logic signed [XW-1:0]                        y_out [LANES],
	output logic signed [spof_pkg::ACC_W-1:0]           acc_out [LANES],
	output logic                                        hold_out [LANES],
	output logic                                        en_out [LANES]
);

	localparam int PB = COORD_BITS + spof_pkg::FRAC_BITS;
	localparam int AW = spof_pkg::ACC_W;
	localparam logic signed [AW-1:0] QUARTER = AW'(64'sd1 <<< 30);
	localparam logic signed [AW-1:0] HALF    = AW'(64'sd1 <<< 31);

	logic signed [PB:0]    dx [LANES];
	logic signed [PB:0]    dy [LANES];
	logic signed [PB:0]    rx [LANES];
	logic signed [PB:0]    ry [LANES];
	logic signed [AW-1:0]  acc_n [LANES];
	logic                  hold_n [LANES];
	logic                  en_n [LANES];
	logic signed [PB:0]    px;
	logic signed [PB:0]    py;

	logic                  valid_s1;
	logic signed [XW-1:0]  x_s1 [LANES];
	logic signed [XW-1:0]  y_s1 [LANES];
	logic signed [AW-1:0]  acc_s1 [LANES];
	logic                  hold_s1 [LANES];
	logic                  en_s1 [LANES];

	// Bring the pixel to the same four fraction bits as the positions
	assign px = $signed({1'b0, pixel_x, {spof_pkg::FRAC_BITS{1'b0}}});
	assign py = $signed({1'b0, pixel_y, {spof_pkg::FRAC_BITS{1'b0}}});

	// Form offsets, catch the axis cases, fold the left half-plane and set lane enables
	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			dx[k] = $signed({1'b0, pos[k][2*PB-1:PB]}) - px;
			dy[k] = $signed({1'b0, pos[k][PB-1:0]}) - py;
			rx[k] = dx[k];
			ry[k] = dy[k];
			acc_n[k] = '0;
			hold_n[k] = 1'b0;
			if (dy[k] == '0) begin
				hold_n[k] = 1'b1;
				acc_n[k] = dx[k][PB] ? HALF : '0;
			end else if (dx[k] == '0) begin
				hold_n[k] = 1'b1;
				acc_n[k] = dy[k][PB] ? -QUARTER : QUARTER;
			end else if (dx[k][PB]) begin
				if (!dy[k][PB]) begin
					rx[k] = dy[k];
					ry[k] = -dx[k];
					acc_n[k] = QUARTER;
				end else begin
					rx[k] = -dy[k];
					ry[k] = dx[k];
					acc_n[k] = -QUARTER;
				end
			end
			if (k < NC)
				en_n[k] = (32'(core_count) > k);
			else
				en_n[k] = (32'(delta_count) > (k - NC));
		end
	end

	// Hold the stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= accept;
	end

	// Load the lane words, scaled up for the rotations
	always_ff @(posedge clk) begin
		for (int k = 0; k < LANES; k++) begin
			x_s1[k]    <= XW'(rx[k]) <<< spof_pkg::PRE_SHIFT;
			y_s1[k]    <= XW'(ry[k]) <<< spof_pkg::PRE_SHIFT;
			acc_s1[k]  <= acc_n[k];
			hold_s1[k] <= hold_n[k];
			en_s1[k]   <= en_n[k];
		end
	end

	assign valid_out = valid_s1;
	assign x_out     = x_s1;
	assign y_out     = y_s1;
	assign acc_out   = acc_s1;
	assign hold_out  = hold_s1;
	assign en_out    = en_s1;

endmodule
`default_nettype wire

// File: rtl/spof_cell.sv
// One micro-rotation cell of the vectoring chain, applied to every lane.
`timescale 1ns / 1ps
`default_nettype none
module spof_cell #(
	parameter int STEP  = 0,
	parameter int LANES = 4,
	parameter int XW    = 34
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              valid_in,
	input  logic signed [XW-1:0]              x_in [LANES],
	input  logic signed [XW-1:0]              y_in [LANES],
	input  logic signed [spof_pkg::ACC_W-1:0] acc_in [LANES],
	input  logic                              hold_in [LANES],
	input  logic                              en_in [LANES],
	output logic                              valid_out,
	output logic signed [XW-1:0]              x_out [LANES],
	output logic signed [XW-1:0]              y_out [LANES],
	output logic signed [spof_pkg::ACC_W-1:0] acc_out [LANES],
	output logic                              hold_out [LANES],
	output logic                              en_out [LANES]
);

	localparam int AW = spof_pkg::ACC_W;
	localparam logic signed [AW-1:0] ATAN_STEP = AW'(spof_pkg::ATAN_TAB[STEP]);

	logic signed [XW-1:0] x_n [LANES];
	logic signed [XW-1:0] y_n [LANES];
	logic signed [AW-1:0] acc_n [LANES];

	logic                 valid_s1;
	logic signed [XW-1:0] x_s1 [LANES];
	logic signed [XW-1:0] y_s1 [LANES];
	logic signed [AW-1:0] acc_s1 [LANES];
	logic                 hold_s1 [LANES];
	logic                 en_s1 [LANES];

	// Rotate towards the x axis by the sign of y; exact lanes pass untouched
	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			x_n[k]   = x_in[k];
			y_n[k]   = y_in[k];
			acc_n[k] = acc_in[k];
			if (!hold_in[k]) begin
				if (!y_in[k][XW-1]) begin
					x_n[k]   = x_in[k] + (y_in[k] >>> STEP);
					y_n[k]   = y_in[k] - (x_in[k] >>> STEP);
					acc_n[k] = acc_in[k] + ATAN_STEP;
				end else begin
					x_n[k]   = x_in[k] - (y_in[k] >>> STEP);
					y_n[k]   = y_in[k] + (x_in[k] >>> STEP);
					acc_n[k] = acc_in[k] - ATAN_STEP;
				end
			end
		end
	end

	// Advance the valid mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= valid_in;
	end

	// Advance the lane words to the next cell
	always_ff @(posedge clk) begin
		for (int k = 0; k < LANES; k++) begin
			x_s1[k]    <= x_n[k];
			y_s1[k]    <= y_n[k];
			acc_s1[k]  <= acc_n[k];
			hold_s1[k] <= hold_in[k];
			en_s1[k]   <= en_in[k];
		end
	end

	assign valid_out = valid_s1;
	assign x_out     = x_s1;
	assign y_out     = y_s1;
	assign acc_out   = acc_s1;
	assign hold_out  = hold_s1;
	assign en_out    = en_s1;

endmodule
`default_nettype wire

// File: rtl/spof_sum.sv
// Output stages: round each lane angle, add cores, subtract deltas, halve.
`timescale 1ns / 1ps
`default_nettype none
module spof_sum #(
	parameter int ANGLE_BITS = spof_pkg::DEF_ANGLE_BITS,
	parameter int LANES      = 4,
	parameter int NC         = 2
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                valid_in,
	input  logic signed [spof_pkg::ACC_W-1:0]   acc_in [LANES],
	input  logic                                en_in [LANES],
	output logic                                done,
	output logic signed [spof_pkg::OUT_W-1:0]   ridge_angle
);

	localparam int AW    = spof_pkg::ACC_W;
	localparam int SHIFT = 32 - ANGLE_BITS;
	localparam int RW    = AW - SHIFT + 1;
	localparam int SW    = RW + 3;
	localparam logic signed [AW-1:0] ROUND = AW'(64'sd1 <<< (SHIFT - 1));

	logic signed [AW-1:0] rnd [LANES];
	logic signed [RW-1:0] term_n [LANES];
	logic signed [SW-1:0] total;
	logic signed [SW-1:0] halved;

	logic                 valid_s1;
	logic signed [RW-1:0] term_s1 [LANES];
	logic                 done_s2;
	logic signed [spof_pkg::OUT_W-1:0] ridge_angle_s2;

	// Round to the output unit, drop idle lanes, negate deltas
	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			rnd[k] = (acc_in[k] + ROUND) >>> SHIFT;
			if (!en_in[k])
				term_n[k] = '0;
			else if (k < NC)
				term_n[k] = RW'(rnd[k]);
			else
				term_n[k] = -RW'(rnd[k]);
		end
	end

	// Add the lane terms and halve, rounding halves upward
	always_comb begin
		total = '0;
		for (int k = 0; k < LANES; k++)
			total = total + SW'(term_s1[k]);
		halved = (total + SW'(1)) >>> 1;
	end

	// Hold the valid marks of both stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_s2  <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
			done_s2  <= valid_s1;
		end
	end

	// Register the terms and the result word
	always_ff @(posedge clk) begin
		for (int k = 0; k < LANES; k++)
			term_s1[k] <= term_n[k];
		ridge_angle_s2 <= spof_pkg::OUT_W'(halved);
	end

	assign done        = done_s2;
	assign ridge_angle = ridge_angle_s2;

endmodule
`default_nettype wire

// File: bench/tb_singular_point_orientation_field.sv
// Self-checking testbench for the singular-point ridge orientation block.
`timescale 1ns / 1ps
module tb_singular_point_orientation_field;

	localparam int COORD_BITS   = spof_pkg::DEF_COORD_BITS;
	localparam int MAX_CORES    = spof_pkg::DEF_MAX_CORES;
	localparam int MAX_DELTAS   = spof_pkg::DEF_MAX_DELTAS;
	localparam int POS_W        = COORD_BITS + spof_pkg::FRAC_BITS;
	localparam int REG_W        = 2 * POS_W;
	localparam int OUT_W        = spof_pkg::OUT_W;
	localparam int PIXEL_MAX    = (1 << COORD_BITS) - 1;
	localparam int CLK_HALF     = 5;
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_PIXELS  = 136;
	localparam int TIMEOUT_NS    = 5_000_000;

	// Angle unit is 2^-16 turn; the rotation accumulator works in 2^-32 turn
	localparam int     ROT_STEPS    = 28;
	localparam int     ROUND_SHIFT  = 16;
	localparam longint QUARTER_TURN = 64'sd16384;
	localparam longint HALF_TURN    = 64'sd32768;
	localparam longint ACC_QUARTER  = 64'sd1073741824;
	localparam longint ATAN_TURNS [ROT_STEPS] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
	};

	typedef enum logic [2:0] {
		REG_CORE_COUNT  = 3'd0,
		REG_DELTA_COUNT = 3'd1,
		REG_CORE0_POS   = 3'd2,
		REG_CORE1_POS   = 3'd3,
		REG_DELTA0_POS  = 3'd4,
		REG_DELTA1_POS  = 3'd5,
		REG_SPARE6      = 3'd6,
		REG_SPARE7      = 3'd7
	} reg_index_e;

	typedef struct {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
	} pixel_t;

	typedef struct {
		logic [COORD_BITS-1:0]   x;
		logic [COORD_BITS-1:0]   y;
		logic signed [OUT_W-1:0] angle;
	} ridge_expect_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        start = 1'b0;
	logic                        busy;
	logic [COORD_BITS-1:0]       pixel_x = '0;
	logic [COORD_BITS-1:0]       pixel_y = '0;
	logic                        done;
	logic signed [OUT_W-1:0]     ridge_angle;
	logic                        wr_en = 1'b0;
	logic [2:0]                  wr_index = '0;
	logic [REG_W-1:0]            wr_data = '0;

	// Shadow of the configuration registers
	logic [1:0]       core_num = '0;
	logic [1:0]       delta_num = '0;
	logic [REG_W-1:0] core_pos_m [2] = '{default: '0};
	logic [REG_W-1:0] delta_pos_m [2] = '{default: '0};

	pixel_t        pixel_queue [$];
	ridge_expect_t predicted_angles [$];
	pixel_t        next_pixel;
	ridge_expect_t oldest;
	int            pixels_in_flight = 0;
	int            idle_left = 0;
	int            error_count = 0;
	bit            steady_stream = 1'b0;

	singular_point_orientation_field u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.done       (done),
		.ridge_angle(ridge_angle),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data)
	);

	always #CLK_HALF clk = ~clk;

	// atan2(dy, dx) in 2^-16 turn by vectoring micro-rotations
	function automatic longint turn_angle(longint dx, longint dy);
		longint x, y, nx, acc;
		int     i;
		if (dy == 0)
			return (dx < 0) ? HALF_TURN : 64'sd0;
		if (dx == 0)
			return (dy > 0) ? QUARTER_TURN : -QUARTER_TURN;
		x = dx;
		y = dy;
		acc = 0;
		// fold the left half-plane onto the right by a quarter turn
		if (dx < 0) begin
			if (dy > 0) begin
				x = dy;
				y = -dx;
				acc = ACC_QUARTER;
			end else begin
				x = -dy;
				y = dx;
				acc = -ACC_QUARTER;
			end
		end
		x = x * 65536;
		y = y * 65536;
		for (i = 0; i < ROT_STEPS; i++) begin
			if (y >= 0) begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				acc = acc + ATAN_TURNS[i];
			end else begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				acc = acc - ATAN_TURNS[i];
			end
			x = nx;
		end
		return (acc + (64'sd1 << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
	endfunction

	function automatic longint point_angle(logic [REG_W-1:0] pos, longint px, longint py);
		longint cx, cy;
		cx = longint'(pos[REG_W-1:POS_W]);
		cy = longint'(pos[POS_W-1:0]);
		return turn_angle(cx - px, cy - py);
	endfunction

	// Half the core angles minus the delta angles, halves rounded upward
	function automatic logic signed [OUT_W-1:0] orientation_at(logic [COORD_BITS-1:0] x,
			logic [COORD_BITS-1:0] y);
		longint px, py, total, half;
		int     nc, nd, k;
		px = longint'(x) * (1 << spof_pkg::FRAC_BITS);
		py = longint'(y) * (1 << spof_pkg::FRAC_BITS);
		nc = (int'(core_num) > MAX_CORES) ? MAX_CORES : int'(core_num);
		nd = (int'(delta_num) > MAX_DELTAS) ? MAX_DELTAS : int'(delta_num);
		if (nc > 2)
			nc = 2;
		if (nd > 2)
			nd = 2;
		total = 0;
		for (k = 0; k < nc; k++)
			total = total + point_angle(core_pos_m[k], px, py);
		for (k = 0; k < nd; k++)
			total = total - point_angle(delta_pos_m[k], px, py);
		half = (total + 1) >>> 1;
		return half[OUT_W-1:0];
	endfunction

	// Mostly back to back, some short pauses, a few long ones
	function automatic int draw_gap();
		int r;
		if (steady_stream)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Random position: edges, whole pixels, or any fraction
	function automatic logic [POS_W-1:0] draw_coord();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		if (r < 4)
			return {COORD_BITS'($urandom_range(0, PIXEL_MAX)), 4'd0};
		return POS_W'($urandom);
	endfunction

	task automatic queue_pixel(int x, int y);
		pixel_t p;
		p.x = COORD_BITS'(x);
		p.y = COORD_BITS'(y);
		pixel_queue = {pixel_queue, p};
		pixels_in_flight++;
	endtask

	// Wait for every pixel to come back, then let the pipeline drain
	task automatic settle();
		while (pixels_in_flight != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(reg_index_e idx, logic [REG_W-1:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		case (idx)
			REG_CORE_COUNT:  core_num = val[1:0];
			REG_DELTA_COUNT: delta_num = val[1:0];
			REG_CORE0_POS:   core_pos_m[0] = val;
			REG_CORE1_POS:   core_pos_m[1] = val;
			REG_DELTA0_POS:  delta_pos_m[0] = val;
			REG_DELTA1_POS:  delta_pos_m[1] = val;
			default: ;
		endcase
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic write_count(reg_index_e idx);
		logic [REG_W-1:0] val;
		val = REG_W'($urandom);
		if ($urandom_range(0, 3) != 0)
			val = '0;
		val[1:0] = 2'($urandom_range(0, 3));
		write_reg(idx, val);
	endtask

	task automatic random_config();
		write_count(REG_CORE_COUNT);
		write_count(REG_DELTA_COUNT);
		write_reg(REG_CORE0_POS, {draw_coord(), draw_coord()});
		write_reg(REG_CORE1_POS, {draw_coord(), draw_coord()});
		write_reg(REG_DELTA0_POS, {draw_coord(), draw_coord()});
		write_reg(REG_DELTA1_POS, {draw_coord(), draw_coord()});
		if ($urandom_range(0, 3) == 0) begin
			if ($urandom_range(0, 1) != 0)
				write_reg(REG_SPARE6, REG_W'($urandom));
			else
				write_reg(REG_SPARE7, REG_W'($urandom));
		end
	endtask

	// Present pixels from the queue; predict each word as it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			pixel_x <= '0;
			pixel_y <= '0;
			idle_left <= 0;
		end else begin
			if (start && !busy) begin
				oldest.x = pixel_x;
				oldest.y = pixel_y;
				oldest.angle = orientation_at(pixel_x, pixel_y);
				predicted_angles = {predicted_angles, oldest};
			end
			if (start && busy) begin
				// hold the word until it is taken
			end else if (idle_left != 0) begin
				start <= 1'b0;
				idle_left <= idle_left - 1;
			end else if (pixel_queue.size() != 0) begin
				next_pixel = pixel_queue.pop_front();
				pixel_x <= next_pixel.x;
				pixel_y <= next_pixel.y;
				start <= 1'b1;
				idle_left <= draw_gap();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Check each result word against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (predicted_angles.size() == 0) begin
				error_count++;
				$display("%0t: ridge_angle expected none got %0d", $time, ridge_angle);
			end else begin
				oldest = predicted_angles.pop_front();
				pixels_in_flight--;
				if (ridge_angle !== oldest.angle) begin
					error_count++;
					$display("%0t: ridge_angle at (%0d,%0d) expected %0d got %0d", $time,
						oldest.x, oldest.y, oldest.angle, ridge_angle);
				end
			end
		end
	end

	initial begin
		#TIMEOUT_NS;
		$display("singular_point_orientation_field verification failed");
		$finish;
	end

	initial begin
		int               phase, n, k, len, x0, row, tx, ty, i;
		logic [REG_W-1:0] base;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Reset state: nothing enabled, angle is zero everywhere
		queue_pixel(0, 0);
		queue_pixel(PIXEL_MAX, PIXEL_MAX);
		settle();

		// One core on a whole pixel: coincident point, axes and all quadrants
		write_reg(REG_CORE_COUNT, REG_W'(1));
		write_reg(REG_DELTA_COUNT, REG_W'(0));
		write_reg(REG_CORE0_POS, {POS_W'(1600), POS_W'(1600)});
		queue_pixel(100, 100);
		queue_pixel(50, 100);
		queue_pixel(150, 100);
		queue_pixel(100, 50);
		queue_pixel(100, 150);
		queue_pixel(50, 50);
		queue_pixel(150, 50);
		queue_pixel(150, 150);
		queue_pixel(50, 150);
		settle();

		// Counts above the limit, positions at the edges, spare indexes ignored
		write_reg(REG_CORE_COUNT, '1);
		write_reg(REG_DELTA_COUNT, REG_W'(3));
		write_reg(REG_CORE0_POS, '1);
		write_reg(REG_CORE1_POS, '0);
		write_reg(REG_DELTA0_POS, {{POS_W{1'b1}}, {POS_W{1'b0}}});
		write_reg(REG_DELTA1_POS, {{POS_W{1'b0}}, {POS_W{1'b1}}});
		write_reg(REG_SPARE6, '1);
		write_reg(REG_SPARE7, '1);
		queue_pixel(0, 0);
		queue_pixel(PIXEL_MAX, 0);
		queue_pixel(0, PIXEL_MAX);
		queue_pixel(PIXEL_MAX, PIXEL_MAX);
		queue_pixel(512, 512);
		settle();

		// Cores on a half turn, deltas just under minus a half turn: top of the range
		write_reg(REG_CORE_COUNT, REG_W'(2));
		write_reg(REG_DELTA_COUNT, REG_W'(2));
		write_reg(REG_CORE0_POS, {POS_W'(1600), POS_W'(1600)});
		write_reg(REG_CORE1_POS, {POS_W'(1600), POS_W'(1600)});
		write_reg(REG_DELTA0_POS, {POS_W'(1600), POS_W'(1599)});
		write_reg(REG_DELTA1_POS, {POS_W'(1600), POS_W'(1599)});
		queue_pixel(200, 100);
		queue_pixel(0, 100);
		queue_pixel(100, 100);
		settle();

		// Swap the roles: bottom of the range
		write_reg(REG_CORE0_POS, {POS_W'(1600), POS_W'(1599)});
		write_reg(REG_CORE1_POS, {POS_W'(1600), POS_W'(1599)});
		write_reg(REG_DELTA0_POS, {POS_W'(1600), POS_W'(1600)});
		write_reg(REG_DELTA1_POS, {POS_W'(1600), POS_W'(1600)});
		queue_pixel(200, 100);
		queue_pixel(0, 100);
		settle();

		// Random settings, each followed by a mix of pixels
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			steady_stream = (phase % 4 == 1);
			random_config();
			n = 0;
			while (n < PHASE_PIXELS) begin
				case ($urandom_range(0, 3))
					0, 1: begin
						queue_pixel($urandom_range(0, PIXEL_MAX), $urandom_range(0, PIXEL_MAX));
						n++;
					end
					2: begin
						// raster run along one row
						len = $urandom_range(8, 32);
						row = $urandom_range(0, PIXEL_MAX);
						x0 = $urandom_range(0, PIXEL_MAX - len);
						for (i = 0; i < len; i++)
							queue_pixel(x0 + i, row);
						n += len;
					end
					default: begin
						// land on or beside a singular point to reach the axis cases
						k = $urandom_range(0, 3);
						base = (k < 2) ? core_pos_m[k] : delta_pos_m[k - 2];
						tx = int'(base[REG_W-1:POS_W+4]) + $urandom_range(0, 4) - 2;
						ty = int'(base[POS_W-1:4]) + $urandom_range(0, 4) - 2;
						if ($urandom_range(0, 1))
							tx = int'(base[REG_W-1:POS_W+4]);
						else
							ty = int'(base[POS_W-1:4]);
						tx = (tx < 0) ? 0 : ((tx > PIXEL_MAX) ? PIXEL_MAX : tx);
						ty = (ty < 0) ? 0 : ((ty > PIXEL_MAX) ? PIXEL_MAX : ty);
						queue_pixel(tx, ty);
						n++;
					end
				endcase
			end
			settle();
		end

		if (error_count == 0)
			$display("singular_point_orientation_field verification clean");
		else
			$display("singular_point_orientation_field verification failed");
		$finish;
	end

endmodule

// File: filelist.f
rtl/spof_pkg.sv
rtl/spof_front.sv
rtl/spof_cell.sv
rtl/spof_sum.sv
rtl/singular_point_orientation_field.sv
bench/tb_singular_point_orientation_field.sv
